[sv/papd_pkg.sv]
// Shared types and constants for the plateau-aware peak detector.
package papd_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int SAMPLE_BITS = 24;
	localparam int CFG_BITS    = 16;

	// Reset values of the configuration registers.
	localparam logic [CFG_BITS-1:0] SEQ_LENGTH_RESET = 16'd0;
	localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = 16'd50;

	// Top value of the index and run-length counters.
	localparam logic [INDEX_BITS-1:0] INDEX_TOP = {INDEX_BITS{1'b1}};

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SEQUENCE_LENGTH = 1'b0,
		REG_MIN_LENGTH      = 1'b1
	} cfg_reg_t;

	// One input item.
	typedef struct packed {
		logic                          first;
		logic signed [SAMPLE_BITS-1:0] sample;
	} sample_item_t;

	// One result item.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] peak_value;
		logic [INDEX_BITS-1:0]         peak_index;
	} peak_item_t;

endpackage

[sv/plateau_aware_peak_detector_unit.sv]
// Streaming peak detector that finds strict peaks and flat-topped peaks.
// A sample passes the input register; its peak, if any, goes to the result register.
// Throughput: one sample per cycle when not stalled; the per-sample state update is
// a single compare of two samples plus counter updates between the input and result
// registers. Reset: arst_n clears the sequence state and pipeline valids and loads
// the configuration defaults (sequence_length 0, min_length 50).
module plateau_aware_peak_detector_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  papd_pkg::sample_item_t     sample_item,
	output logic                       peak_valid,
	input  logic                       peak_stall,
	output papd_pkg::peak_item_t       peak_item,
	input  logic                       cfg_write,
	input  papd_pkg::cfg_reg_t         cfg_index,
	input  logic [papd_pkg::CFG_BITS-1:0] cfg_data
);
	import papd_pkg::*;

	// Configuration registers.
	logic [CFG_BITS-1:0] seq_length_q;
	logic [CFG_BITS-1:0] min_length_q;

	// Input stage.
	logic         valid_s1;
	sample_item_t item_s1;

	// Sequence state.
	logic signed [SAMPLE_BITS-1:0] prev_sample_q;
	logic [INDEX_BITS-1:0]         sample_index_q;
	logic                          last_step_up_q;
	logic                          flat_after_rise_q;
	logic [INDEX_BITS-1:0]         flat_start_q;
	logic [INDEX_BITS-1:0]         flat_run_len_q;

	// Result register.
	logic       peak_valid_q;
	peak_item_t peak_item_q;

	// Working values for the sample in the input stage.
	logic                  advance;
	logic [INDEX_BITS-1:0] idx;
	logic                  cur_up;
	logic                  cur_flat;
	logic [INDEX_BITS-1:0] cur_start;
	logic [INDEX_BITS-1:0] cur_len;
	logic                  in_range;
	logic                  rise;
	logic                  level;
	logic                  fall;
	logic [INDEX_BITS:0]   half_run;
	logic [INDEX_BITS:0]   pos;
	logic [INDEX_BITS+1:0] pos_end;
	logic                  peak_found;
	logic                  emit;
	logic                  nxt_up;
	logic                  nxt_flat;
	logic [INDEX_BITS-1:0] nxt_start;
	logic [INDEX_BITS-1:0] nxt_len;

	// The pipeline moves whenever the result register is free or being taken.
	assign advance      = !(peak_valid_q && peak_stall);
	assign sample_stall = !advance;
	assign peak_valid   = peak_valid_q;
	assign peak_item    = peak_item_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= SEQ_LENGTH_RESET;
			min_length_q <= MIN_LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SEQUENCE_LENGTH: seq_length_q <= cfg_data;
				REG_MIN_LENGTH:      min_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sample_valid) begin
			item_s1 <= sample_item;
		end
	end

	// A first mark starts the sequence state over before the sample is used.
	always_comb begin
		idx       = item_s1.first ? '0 : sample_index_q;
		cur_up    = item_s1.first ? 1'b0 : last_step_up_q;
		cur_flat  = item_s1.first ? 1'b0 : flat_after_rise_q;
		cur_start = item_s1.first ? '0 : flat_start_q;
		cur_len   = item_s1.first ? '0 : flat_run_len_q;
	end

	// Classify the step and work out the candidate peak position.
	always_comb begin
		in_range = idx < seq_length_q;
		rise     = (idx != '0) && (item_s1.sample > prev_sample_q);
		level    = (idx != '0) && (item_s1.sample == prev_sample_q);
		fall     = (idx != '0) && (item_s1.sample < prev_sample_q);
		half_run = ({1'b0, cur_len} + 1'b1) >> 1;
		if (cur_flat) begin
			pos = {1'b0, cur_start} + half_run;
		end else begin
			pos = {1'b0, idx} - 1'b1;
		end
		pos_end    = {1'b0, pos} + 2'd3;
		peak_found = fall && (cur_flat || cur_up);
		emit       = valid_s1 && in_range && peak_found
			&& (seq_length_q >= min_length_q)
			&& (pos != '0)
			&& (pos_end <= {2'b00, seq_length_q});
	end

	// Next sequence state.
	always_comb begin
		nxt_up    = cur_up;
		nxt_flat  = cur_flat;
		nxt_start = cur_start;
		nxt_len   = cur_len;
		if (rise) begin
			nxt_flat = 1'b0;
			nxt_up   = 1'b1;
		end else if (level) begin
			if (cur_flat) begin
				if (cur_len != INDEX_TOP) begin
					nxt_len = cur_len + 1'b1;
				end
			end else if (cur_up) begin
				nxt_flat  = 1'b1;
				nxt_start = idx - 1'b1;
				nxt_len   = {{(INDEX_BITS-1){1'b0}}, 1'b1};
			end
			nxt_up = 1'b0;
		end else if (fall) begin
			nxt_flat = 1'b0;
			nxt_up   = 1'b0;
		end
	end

	// State update; a sample past the set length only applies a first mark's restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q     <= '0;
			sample_index_q    <= '0;
			last_step_up_q    <= 1'b0;
			flat_after_rise_q <= 1'b0;
			flat_start_q      <= '0;
			flat_run_len_q    <= '0;
		end else if (advance && valid_s1) begin
			if (in_range) begin
				prev_sample_q     <= item_s1.sample;
				sample_index_q    <= (idx != INDEX_TOP) ? idx + 1'b1 : idx;
				last_step_up_q    <= nxt_up;
				flat_after_rise_q <= nxt_flat;
				flat_start_q      <= nxt_start;
				flat_run_len_q    <= nxt_len;
			end else begin
				sample_index_q    <= idx;
				last_step_up_q    <= cur_up;
				flat_after_rise_q <= cur_flat;
				flat_start_q      <= cur_start;
				flat_run_len_q    <= cur_len;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_valid_q <= 1'b0;
		end else if (advance) begin
			peak_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			peak_item_q.peak_value <= prev_sample_q;
			peak_item_q.peak_index <= pos[INDEX_BITS-1:0];
		end
	end

	// A stall toward the source only comes from a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> peak_valid_q)
		else $error("input stalled without a pending result");

	// Index zero can never be reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid_q |-> (peak_item_q.peak_index != '0))
		else $error("peak reported at index zero");

	// A flat run after a rise and a pending rise exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		flat_after_rise_q |-> !last_step_up_q)
		else $error("flat run and rise flags both set");

	// An open flat run always has at least one equal step.
	assert property (@(posedge clk) disable iff (!arst_n)
		flat_after_rise_q |-> (flat_run_len_q != '0))
		else $error("open flat run with zero length");

endmodule

[sim/plateau_aware_peak_detector_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the plateau-aware peak detector unit.
module plateau_aware_peak_detector_unit_tb;
	import papd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 100;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_item_t        sample_item  = '0;
	logic                peak_valid;
	logic                peak_stall   = 1'b0;
	peak_item_t          peak_item;
	logic                cfg_write    = 1'b0;
	cfg_reg_t            cfg_index    = REG_SEQUENCE_LENGTH;
	logic [CFG_BITS-1:0] cfg_data     = '0;

	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	int   errors        = 0;
	int   cycles        = 0;
	int   live_samples  = 0;
	logic hold_on       = 1'b0;
	event hold_go;

	logic signed [SAMPLE_BITS-1:0] walk_val = '0;

	// Predicted copy of the detector's registers and tracking state.
	logic [CFG_BITS-1:0]           cur_seq_len = SEQ_LENGTH_RESET;
	logic [CFG_BITS-1:0]           cur_min_len = MIN_LENGTH_RESET;
	logic signed [SAMPLE_BITS-1:0] last_smp    = '0;
	logic [INDEX_BITS-1:0]         next_pos    = '0;
	logic [INDEX_BITS-1:0]         plat_start  = '0;
	logic [INDEX_BITS-1:0]         plat_len    = '0;
	bit                            rising      = 1'b0;
	bit                            on_plateau  = 1'b0;
	peak_item_t                    pending_peaks[$];

	plateau_aware_peak_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.peak_valid   (peak_valid),
		.peak_stall   (peak_stall),
		.peak_item    (peak_item),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Queue a peak if the position and the sequence length allow reporting it.
	function automatic void report_peak(input longint unsigned pos);
		peak_item_t p;
		if (cur_seq_len >= cur_min_len && pos >= 1 && pos + 3 <= cur_seq_len) begin
			p.peak_value = last_smp;
			p.peak_index = pos[INDEX_BITS-1:0];
			pending_peaks = {pending_peaks, p};
		end
	endfunction

	// Advance the predicted state by one accepted sample.
	function automatic void track_sample(input sample_item_t it);
		logic [INDEX_BITS-1:0] pos;
		if (it.first) begin
			next_pos   = '0;
			rising     = 1'b0;
			on_plateau = 1'b0;
			plat_start = '0;
			plat_len   = '0;
		end
		pos = next_pos;
		if (pos < cur_seq_len) begin
			live_samples++;
			if (pos != 0) begin
				if (it.sample > last_smp) begin
					on_plateau = 1'b0;
					rising     = 1'b1;
				end else if (it.sample == last_smp) begin
					// A flat step only opens a plateau right after a rise.
					if (on_plateau) begin
						if (plat_len != INDEX_TOP)
							plat_len = plat_len + 1'b1;
					end else if (rising) begin
						on_plateau = 1'b1;
						plat_start = pos - 1'b1;
						plat_len   = INDEX_BITS'(1);
					end
					rising = 1'b0;
				end else begin
					// A fall confirms either the plateau middle or the last sample.
					if (on_plateau)
						report_peak(64'(plat_start) + (64'(plat_len) + 1) / 2);
					else if (rising)
						report_peak(64'(pos) - 1);
					on_plateau = 1'b0;
					rising     = 1'b0;
				end
			end
			last_smp = it.sample;
			if (pos != INDEX_TOP)
				next_pos = pos + 1'b1;
		end
	endfunction

	// Next value of a random walk with flat steps, jumps and extremes.
	function automatic logic signed [SAMPLE_BITS-1:0] next_walk();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			walk_val = walk_val + SAMPLE_BITS'($urandom_range(200, 1));
		else if (r < 60)
			walk_val = walk_val - SAMPLE_BITS'($urandom_range(200, 1));
		else if (r < 85)
			walk_val = walk_val;
		else if (r < 93)
			walk_val = SAMPLE_BITS'($urandom);
		else if (r[0])
			walk_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else
			walk_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		return walk_val;
	endfunction

	// Offer one sample, with random idle cycles ahead of it, until it transfers.
	task automatic send_sample(input logic first, input logic signed [SAMPLE_BITS-1:0] value);
		sample_item_t it;
		it.first  = first;
		it.sample = value;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item  <= it;
		do
			@(posedge clk);
		while (sample_stall);
		track_sample(it);
	endtask

	// Stop sending and wait until every predicted peak has arrived.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_peaks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_BITS-1:0] value);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (which == REG_SEQUENCE_LENGTH)
			cur_seq_len = value;
		else
			cur_min_len = value;
	endtask

	task automatic set_config(input logic [CFG_BITS-1:0] seq, input logic [CFG_BITS-1:0] min);
		write_reg(REG_SEQUENCE_LENGTH, seq);
		write_reg(REG_MIN_LENGTH, min);
	endtask

	// Samples before any first mark, and a register change while a rise is pending.
	task automatic test_no_first_mark();
		send_sample(1'b0, 24'sd300);
		send_sample(1'b1, -24'sd300);
		set_config(16'd8, 16'd0);
		send_sample(1'b0, 24'sd0);
		send_sample(1'b0, 24'sd7);
		send_sample(1'b0, 24'sd3);
		send_sample(1'b0, 24'sd9);
		write_reg(REG_MIN_LENGTH, 16'd9);
		send_sample(1'b0, 24'sd1);
		write_reg(REG_MIN_LENGTH, 16'd0);
	endtask

	// Strict peaks at full range, odd and even plateaus, plateaus not after a rise,
	// a plateau ended by a rise and a plateau that runs into the end of the sequence.
	task automatic test_shapes();
		int shape [21];
		shape = '{-8388608, 8388607, -8388608, 0, 0, -5, 10, 10, 10, 9, 9, 8,
			20, 20, 30, 29, 29, 29, 40, 40, 0};
		set_config(16'd20, 16'd0);
		for (int i = 0; i < 21; i++)
			send_sample(i == 0, SAMPLE_BITS'(shape[i]));
	endtask

	// Lowest and highest reportable indices, and the minimum length.
	task automatic test_index_bounds();
		int rise_fall [6];
		int late_peak [6];
		rise_fall = '{0, 5, 0, 5, 0, 0};
		late_peak = '{0, 0, 0, 0, 5, 0};
		set_config(16'd6, 16'd6);
		for (int i = 0; i < 6; i++)
			send_sample(i == 0, SAMPLE_BITS'(rise_fall[i]));
		for (int i = 0; i < 6; i++)
			send_sample(i == 0, SAMPLE_BITS'(late_peak[i]));
		write_reg(REG_MIN_LENGTH, 16'd7);
		for (int i = 0; i < 6; i++)
			send_sample(i == 0, SAMPLE_BITS'(rise_fall[i]));
	endtask

	// The receiver holds off while a zigzag keeps producing peaks.
	task automatic test_hold_off();
		send_idle_pct = 0;
		stall_pct     = 0;
		set_config(16'hFFFF, 16'd0);
		-> hold_go;
		for (int i = 0; i < 120; i++)
			send_sample(i == 0, (i % 2) ? 24'sd100 : -24'sd100);
		wait_drained();
		for (int i = 0; i < 40; i++)
			send_sample(1'b0, (i % 2) ? -24'sd70000 : 24'sd70000);
		wait_drained();
	endtask

	// Noise, broken sequences or well-formed sequences at the current length.
	task automatic send_sequence();
		int kind;
		int span;
		kind = $urandom_range(9);
		span = (cur_seq_len > 60) ? $urandom_range(60, 3) : int'(cur_seq_len);
		if (kind == 0) begin
			repeat ($urandom_range(8, 1))
				send_sample(1'($urandom_range(1)), SAMPLE_BITS'($urandom));
		end else if (kind == 1) begin
			send_sample(1'b1, next_walk());
			repeat ($urandom_range(span, 0))
				send_sample(1'b0, next_walk());
		end else begin
			send_sample(1'b1, next_walk());
			repeat (span - 1 + $urandom_range(3))
				send_sample(1'b0, next_walk());
		end
	endtask

	// Random settings and sequences under one idling pattern.
	task automatic random_phase(input int idle_pct, input int hold_pct);
		int start;
		logic [CFG_BITS-1:0] seq;
		logic [CFG_BITS-1:0] min;
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
		start         = live_samples;
		while (live_samples - start < PHASE_ITEMS) begin
			case ($urandom_range(7))
				0: seq = CFG_BITS'($urandom_range(2));
				1: seq = 16'hFFFF;
				default: seq = CFG_BITS'($urandom_range(40, 4));
			endcase
			case ($urandom_range(5))
				0: min = 16'd0;
				1: min = 16'hFFFF;
				2: min = seq;
				3: min = seq + 1'b1;
				4: min = MIN_LENGTH_RESET;
				default: min = CFG_BITS'($urandom_range(seq));
			endcase
			set_config(seq, min);
			repeat (4) send_sequence();
		end
	endtask

	// The receiver's long hold-off, counted here in cycles.
	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// Check each peak transfer against the oldest prediction and drive the stall.
	always @(posedge clk) begin : peak_checker
		peak_item_t want;
		if (arst_n && peak_valid && !peak_stall) begin
			if (pending_peaks.size() == 0) begin
				errors++;
				$display("%0t: unexpected peak: expected none, actual value %0d index %0d",
					$time, peak_item.peak_value, peak_item.peak_index);
			end else begin
				want = pending_peaks.pop_front();
				if (peak_item.peak_value !== want.peak_value) begin
					errors++;
					$display("%0t: peak_value mismatch: expected %0d, actual %0d",
						$time, want.peak_value, peak_item.peak_value);
				end
				if (peak_item.peak_index !== want.peak_index) begin
					errors++;
					$display("%0t: peak_index mismatch: expected %0d, actual %0d",
						$time, want.peak_index, peak_item.peak_index);
				end
			end
		end
		peak_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_first_mark();
		test_shapes();
		test_index_bounds();
		test_hold_off();
		random_phase(0, 0);
		random_phase(81, 0);
		random_phase(0, 81);
		random_phase(6, 6);
		wait_drained();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
